// File: hw/rtl/mbd_pkg.sv
`default_nettype none

package mbd_pkg;

    localparam int unsigned NumButtonsDefault = 8;
    localparam int unsigned PinWidth          = 8;
    localparam int unsigned MaskWidth         = 8;
    localparam int unsigned ButtonIdxWidth    = 3;
    localparam int unsigned TickWidth         = 24;
    localparam int unsigned CountWidth        = 8;
    localparam int unsigned CfgIndexWidth     = 1;
    localparam int unsigned CfgDataWidth      = 24;

    localparam logic [CfgIndexWidth-1:0] REG_SAMPLE_INTERVAL  = 1'b0;
    localparam logic [CfgIndexWidth-1:0] REG_REQUIRED_SAMPLES = 1'b1;

    localparam logic [TickWidth-1:0]  TICK_MAX         = {TickWidth{1'b1}};
    localparam logic [TickWidth-1:0]  INTERVAL_RESET   = '0;
    localparam logic [CountWidth-1:0] REQUIRED_RESET   = CountWidth'(3);

    typedef struct packed {
        logic                      valid;
        logic [ButtonIdxWidth-1:0] button;
        logic                      released;
    } mbd_event_t;

endpackage

`default_nettype wire

// File: hw/rtl/mbd_if.sv
`default_nettype none

interface mbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pin_levels;
    logic       take_event;

    modport source (output valid, output pin_levels, output take_event, input ready);
    modport sink   (input valid, input pin_levels, input take_event, output ready);
endinterface

interface mbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pressed_mask;
    logic       event_valid;
    logic [2:0] event_button;
    logic       event_released;

    modport source (output valid, output pressed_mask, output event_valid,
                    output event_button, output event_released, input ready);
    modport sink   (input valid, input pressed_mask, input event_valid,
                    input event_button, input event_released, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mbd_lane.sv
`default_nettype none

module mbd_lane (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           sample_en,
    input  wire logic                           pin,
    input  wire logic [mbd_pkg::CountWidth-1:0] required_samples,
    output logic                                level,
    output logic                                flip
);
    import mbd_pkg::*;

    logic                  level_reg;
    logic                  level_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic [CountWidth-1:0] count_inc;
    logic                  mismatch;

    assign mismatch  = pin != level_reg;
    // saturating count of differing samples
    assign count_inc = (&count_reg) ? count_reg : count_reg + CountWidth'(1);
    assign flip      = sample_en && mismatch && (count_inc >= required_samples);

    always_comb
    begin
        level_next = level_reg;
        count_next = count_reg;
        if (sample_en)
        begin
            if (!mismatch)
                count_next = '0;
            else if (flip)
            begin
                level_next = pin;
                count_next = '0;
            end
            else
                count_next = count_inc;
        end
    end

    // post-sample level for this request's result
    assign level = level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mbd_event.sv
`default_nettype none

module mbd_event #(
    parameter int unsigned NUM_BUTTONS = mbd_pkg::NumButtonsDefault
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic                   take,
    input  wire logic [NUM_BUTTONS-1:0] flip,
    input  wire logic [NUM_BUTTONS-1:0] level,
    output mbd_pkg::mbd_event_t         event_out,
    output logic                        pending
);
    import mbd_pkg::*;

    logic                      pending_reg;
    logic                      pending_next;
    logic [ButtonIdxWidth-1:0] index_reg;
    logic [ButtonIdxWidth-1:0] index_next;
    logic                      release_reg;
    logic                      release_next;
    logic [ButtonIdxWidth-1:0] first_idx;
    logic                      first_level;
    logic                      any_flip;
    logic                      capture;
    logic                      pending_post;

    // lowest-numbered flipping lane wins
    always_comb
    begin
        first_idx   = '0;
        first_level = 1'b0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if (flip[i])
            begin
                first_idx   = ButtonIdxWidth'(i);
                first_level = level[i];
            end
        end
    end

    assign any_flip     = |flip;
    assign capture      = !pending_reg && any_flip;
    assign pending_post = pending_reg || any_flip;

    always_comb
    begin
        index_next   = capture ? first_idx : index_reg;
        release_next = capture ? first_level : release_reg;
        pending_next = pending_reg;
        if (accept)
            pending_next = pending_post && !take;
    end

    assign event_out.valid    = pending_post;
    assign event_out.button   = pending_post ? index_next : '0;
    assign event_out.released = pending_post ? release_next : 1'b0;
    assign pending            = pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            index_reg   <= '0;
            release_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            index_reg   <= index_next;
            release_reg <= release_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/multi_button_debouncer.sv
`default_nettype none

// channel  dir  payload                                              handshake
// in_ch    in   pin_levels[7:0], take_event                          valid/ready
// out_ch   out  pressed_mask[7:0], event_valid, event_button[2:0],   valid/ready
//               event_released
// cfg      in   cfg_index, cfg_wdata[23:0]                           cfg_we
//
// one request per cycle; its result appears in the output register in the next cycle
// the tick counter, per-button lanes and event latch all update in the accepting cycle
// in_ch.ready is high whenever the output register is empty or being drained
// reset empties the output register, clears all lanes, the tick counter and the latch
// a stalled output holds its result and blocks further requests until it is taken

module multi_button_debouncer #(
    parameter int unsigned NUM_BUTTONS = mbd_pkg::NumButtonsDefault
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    mbd_in_if.sink                                 in_ch,
    mbd_out_if.source                              out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [mbd_pkg::CfgIndexWidth-1:0] cfg_index,
    input  wire logic [mbd_pkg::CfgDataWidth-1:0]  cfg_wdata
);
    import mbd_pkg::*;

    logic [TickWidth-1:0]  interval_reg;
    logic [CountWidth-1:0] required_reg;
    logic [TickWidth-1:0]  tick_reg;
    logic [TickWidth-1:0]  tick_next;
    logic [TickWidth-1:0]  tick_inc;
    logic                  sample;
    logic                  sample_en;
    logic                  accept;

    logic [NUM_BUTTONS-1:0] pins;
    logic [NUM_BUTTONS-1:0] lane_level;
    logic [NUM_BUTTONS-1:0] lane_flip;
    logic [MaskWidth-1:0]   mask;
    mbd_event_t             ev;
    logic                   ev_pending;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [MaskWidth-1:0]  mask_reg;
    mbd_event_t            ev_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            required_reg <= REQUIRED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_INTERVAL:  interval_reg <= cfg_wdata[TickWidth-1:0];
                REG_REQUIRED_SAMPLES: required_reg <= cfg_wdata[CountWidth-1:0];
                default: ;
            endcase
        end
    end

    assign tick_inc  = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + TickWidth'(1);
    assign sample    = tick_inc >= interval_reg;
    assign sample_en = accept && sample;
    assign tick_next = accept ? (sample ? '0 : tick_inc) : tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_reg <= '0;
        else
            tick_reg <= tick_next;
    end

    // pins above the input width read as level 0
    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
            pins[i] = (i < PinWidth) ? in_ch.pin_levels[i % PinWidth] : 1'b0;
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++)
    begin : g_lane
        mbd_lane u_lane (
            .clk              (clk),
            .rst_n            (rst_n),
            .sample_en        (sample_en),
            .pin              (pins[g]),
            .required_samples (required_reg),
            .level            (lane_level[g]),
            .flip             (lane_flip[g])
        );
    end

    mbd_event #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_event (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .take      (in_ch.take_event),
        .flip      (lane_flip),
        .level     (lane_level),
        .event_out (ev),
        .pending   (ev_pending)
    );

    always_comb
    begin
        for (int i = 0; i < MaskWidth; i++)
            mask[i] = (i < NUM_BUTTONS) ? !lane_level[i % NUM_BUTTONS] : 1'b0;
    end

    assign out_valid_next = accept || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mask_reg <= mask;
            ev_reg   <= ev;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.pressed_mask   = mask_reg;
    assign out_ch.event_valid    = ev_reg.valid;
    assign out_ch.event_button   = ev_reg.button;
    assign out_ch.event_released = ev_reg.released;

`ifndef SYNTH
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result");

    a_flip_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_flip) |-> sample_en)
        else $error("lane flipped outside a sample");

    a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.take_event) |=> !ev_pending)
        else $error("take did not empty the event latch");

    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_en |=> $stable(lane_level) || sample_en)
        else $error("debounced level moved without a sample");
`endif

endmodule

`default_nettype wire
